@@ hw/rtl/rspr_pkg.sv @@
// ----------------------------------------------------------------------------
// rspr_pkg
// Shared types, codes and helpers of the serial protocol packet receiver.
// ----------------------------------------------------------------------------
package rspr_pkg;

  localparam int BUF_DEPTH_DEF = 32;

  // protocol characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

  // result kinds
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_BYTE    = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_OVERRUN = 3'd3;
  localparam logic [2:0] KIND_FAIL    = 3'd4;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_BODY,
    ST_HI,
    ST_LO,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  // non-hex characters read as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/rspr_in_if.sv @@
// ----------------------------------------------------------------------------
// rspr_in_if
// Character channel: one received character or a link failure per item.
// ----------------------------------------------------------------------------
interface rspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  logic       link_lost;

  modport source (output valid, output rx_char, output link_lost, input ready);
  modport sink (input valid, input rx_char, input link_lost, output ready);
endinterface

@@ hw/rtl/rspr_out_if.sv @@
// ----------------------------------------------------------------------------
// rspr_out_if
// Result channel: ack characters, payload bytes and status items.
// ----------------------------------------------------------------------------
interface rspr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

@@ hw/rtl/rspr_ram.sv @@
// ----------------------------------------------------------------------------
// rspr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rspr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rspr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rspr_ctrl
// Packet parser and readout sequencer around the payload RAM.
// ----------------------------------------------------------------------------
module rspr_ctrl #(
  parameter int BUF_DEPTH = rspr_pkg::BUF_DEPTH_DEF,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int CW = $clog2(BUF_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            no_ack,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char,
  input  logic            in_lost,
  input  logic            res_free,
  output logic            res_load,
  output rspr_pkg::res_t  res,
  output logic            ram_we,
  output logic [AW-1:0]   ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic [AW-1:0]   ram_raddr,
  input  logic [7:0]      ram_rdata
);

  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  rspr_pkg::state_t state, state_next;
  logic [7:0]    sum;
  logic [3:0]    hi_nib;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;

  logic          parse_st;
  logic          take;
  logic [CW-1:0] count_inc;
  logic          overrun;
  logic [7:0]    sent;
  logic          match;
  logic          is_start;
  logic          is_end;
  logic          rd_last;

  always_comb begin
    parse_st = (state == rspr_pkg::ST_HUNT) || (state == rspr_pkg::ST_BODY) ||
               (state == rspr_pkg::ST_HI) || (state == rspr_pkg::ST_LO);
  end

  assign in_ready  = parse_st && res_free;
  assign take      = in_valid && in_ready;
  assign count_inc = count + CW'(1);
  assign overrun   = (count_inc == DEPTH_C);
  assign sent      = {hi_nib, rspr_pkg::hex_value(in_char)};
  assign match     = (sent == sum);
  assign is_start  = (in_char == rspr_pkg::CH_START);
  assign is_end    = (in_char == rspr_pkg::CH_END);
  assign rd_last   = ((rd_idx + CW'(1)) == count);

  assign ram_waddr = count[AW-1:0];
  assign ram_wdata = in_char;
  assign ram_raddr = rd_idx[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rspr_pkg::ST_HUNT: begin
        if (take && !in_lost && is_start) state_next = rspr_pkg::ST_BODY;
      end
      rspr_pkg::ST_BODY: begin
        if (take) begin
          if (in_lost) state_next = rspr_pkg::ST_HUNT;
          else if (is_start) state_next = rspr_pkg::ST_BODY;
          else if (is_end) state_next = rspr_pkg::ST_HI;
          else if (overrun) state_next = rspr_pkg::ST_HUNT;
        end
      end
      rspr_pkg::ST_HI: begin
        if (take) state_next = in_lost ? rspr_pkg::ST_HUNT : rspr_pkg::ST_LO;
      end
      rspr_pkg::ST_LO: begin
        if (take) begin
          if (in_lost || (!no_ack && !match)) state_next = rspr_pkg::ST_HUNT;
          else if (count == '0) state_next = rspr_pkg::ST_DONE;
          else state_next = rspr_pkg::ST_RD_ISSUE;
        end
      end
      rspr_pkg::ST_RD_ISSUE: begin
        state_next = rspr_pkg::ST_RD_WAIT;
      end
      rspr_pkg::ST_RD_WAIT: begin
        if (res_free) state_next = rd_last ? rspr_pkg::ST_DONE : rspr_pkg::ST_RD_ISSUE;
      end
      rspr_pkg::ST_DONE: begin
        if (res_free) state_next = rspr_pkg::ST_HUNT;
      end
      default: state_next = rspr_pkg::ST_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    res_load  = 1'b0;
    res.kind  = rspr_pkg::KIND_FAIL;
    res.value = 8'd0;
    res.last  = 1'b1;
    ram_we    = 1'b0;
    case (state)
      rspr_pkg::ST_HUNT, rspr_pkg::ST_HI: begin
        res_load = take && in_lost;
      end
      rspr_pkg::ST_BODY: begin
        if (take && in_lost) begin
          res_load = 1'b1;
        end else if (take && !is_start && !is_end) begin
          ram_we = 1'b1;
          if (overrun) begin
            res_load = 1'b1;
            res.kind = rspr_pkg::KIND_OVERRUN;
          end
        end
      end
      rspr_pkg::ST_LO: begin
        if (take && in_lost) begin
          res_load = 1'b1;
        end else if (take && !no_ack) begin
          res_load  = 1'b1;
          res.kind  = rspr_pkg::KIND_ACK;
          res.value = match ? rspr_pkg::CH_PLUS : rspr_pkg::CH_MINUS;
          res.last  = !match;
        end
      end
      rspr_pkg::ST_RD_WAIT: begin
        res_load  = res_free;
        res.kind  = rspr_pkg::KIND_BYTE;
        res.value = ram_rdata;
        res.last  = 1'b0;
      end
      rspr_pkg::ST_DONE: begin
        res_load  = res_free;
        res.kind  = rspr_pkg::KIND_DONE;
        res.value = 8'(count);
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rspr_pkg::ST_HUNT;
      sum    <= 8'd0;
      hi_nib <= 4'd0;
      count  <= '0;
      rd_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        rspr_pkg::ST_HUNT: begin
          if (take) begin
            sum    <= 8'd0;
            hi_nib <= 4'd0;
            count  <= '0;
          end
        end
        rspr_pkg::ST_BODY: begin
          if (take) begin
            if (in_lost || is_start || (!is_end && overrun)) begin
              sum    <= 8'd0;
              hi_nib <= 4'd0;
              count  <= '0;
            end else if (!is_end) begin
              sum   <= sum + in_char;
              count <= count_inc;
            end
          end
        end
        rspr_pkg::ST_HI: begin
          if (take) begin
            if (in_lost) begin
              sum    <= 8'd0;
              hi_nib <= 4'd0;
              count  <= '0;
            end else begin
              hi_nib <= rspr_pkg::hex_value(in_char);
            end
          end
        end
        rspr_pkg::ST_LO: begin
          if (take) begin
            rd_idx <= '0;
            if (in_lost || (!no_ack && !match)) begin
              sum    <= 8'd0;
              hi_nib <= 4'd0;
              count  <= '0;
            end
          end
        end
        rspr_pkg::ST_RD_WAIT: begin
          if (res_free) rd_idx <= rd_idx + CW'(1);
        end
        rspr_pkg::ST_DONE: begin
          if (res_free) begin
            sum    <= 8'd0;
            hi_nib <= 4'd0;
            count  <= '0;
          end
        end
        default: begin
          rd_idx <= rd_idx;
        end
      endcase
    end
  end

  // payload count always stays below the buffer depth
  a_count_below_depth: assert property (@(posedge clk) disable iff (rst)
    count < DEPTH_C)
    else $error("payload count reached buffer depth");

  a_write_only_in_body: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == rspr_pkg::ST_BODY) && take)
    else $error("payload write outside packet body");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == rspr_pkg::ST_RD_ISSUE) || (state == rspr_pkg::ST_RD_WAIT)) |->
      (rd_idx < count))
    else $error("readout index beyond payload");

  a_done_returns: assert property (@(posedge clk) disable iff (rst)
    ((state == rspr_pkg::ST_DONE) && res_free) |=>
      (state == rspr_pkg::ST_HUNT) && (count == '0) && (sum == 8'd0))
    else $error("completion did not return to hunting with cleared packet");

endmodule

@@ hw/rtl/rsp_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_receiver
// Receive side of a remote debug serial protocol: framing, checksum, readout.
// ----------------------------------------------------------------------------
// in_ch carries one received character (or a link failure) per item. out_ch
// carries results: ack characters, payload bytes, completion with the payload
// length, overrun and link failure; last marks the final result of an item.
// cfg_we/cfg_wdata write no_ack_mode; write it only while the block is idle.
// Characters are taken one per cycle while no readout runs and the result
// register is free; an ack, overrun or link failure result shows up on
// out_ch the cycle after the item that causes it is accepted. The second
// checksum digit of a good packet (any packet in no_ack_mode) starts a
// readout from the payload RAM: any ack, a RAM read and a result load per byte,
// then the completion; in_ch is held off until the completion is loaded.
// A stall on out_ch holds the result register and the readout sequencer,
// and in_ch is not ready until the result register can take a new result.
// Reset returns the block to hunting for a start character and clears
// no_ack_mode; the payload RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module rsp_packet_receiver #(
  parameter int BUF_DEPTH = rspr_pkg::BUF_DEPTH_DEF,
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  rspr_in_if.sink           in_ch,
  rspr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  logic           no_ack;
  logic           out_valid;
  rspr_pkg::res_t out_q;
  logic           res_free;
  logic           res_load;
  rspr_pkg::res_t res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_ack <= 1'b0;
    end else if (cfg_we) begin
      no_ack <= cfg_wdata;
    end
  end

  // result register between the sequencer and the output channel
  assign res_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_load) begin
      out_q <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.kind  = out_q.kind;
  assign out_ch.value = out_q.value;
  assign out_ch.last  = out_q.last;

  rspr_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .no_ack    (no_ack),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_char   (in_ch.rx_char),
    .in_lost   (in_ch.link_lost),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rspr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
